>>> hw/rtl/ket_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ket_pkg
// Types and constants shared by the keyed expiry table.
// ----------------------------------------------------------------------------
package ket_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int DEFAULT_DELAY_BITS  = 8;
  localparam int KEY_W     = 64;
  localparam int HANDLE_W  = 16;
  localparam int DELAY_W   = 8;
  localparam int TIME_W    = 32;
  localparam int MAX_REL   = 16;
  localparam int REL_W     = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_REMOVE  = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   expiry;
    logic [TIME_W-1:0]   order;
  } entry_t;

  typedef struct packed {
    kind_t               kind;
    status_t             status;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic                present;
    logic                last;
  } result_t;

endpackage

>>> hw/rtl/ket_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ket_ifs
// Command and result channels of the keyed expiry table.
// ----------------------------------------------------------------------------
interface ket_in_if;
  import ket_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [KEY_W-1:0]    key;
  logic [HANDLE_W-1:0] handle;
  logic [DELAY_W-1:0]  delay;
  modport source (output valid, command, key, handle, delay, input ready);
  modport sink   (input valid, command, key, handle, delay, output ready);
endinterface

interface ket_out_if;
  import ket_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [1:0]          status;
  logic [KEY_W-1:0]    out_key;
  logic [HANDLE_W-1:0] out_handle;
  logic                present;
  logic                last;
  modport source (output valid, kind, status, out_key, out_handle, present, last,
                  input ready);
  modport sink   (input valid, kind, status, out_key, out_handle, present, last,
                  output ready);
endinterface

>>> hw/rtl/ket_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ket_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ket_store #(
  parameter int TABLE_DEPTH = ket_pkg::DEFAULT_TABLE_DEPTH,
  localparam int IW = $clog2(TABLE_DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [IW-1:0]   waddr,
  input  ket_pkg::entry_t wdata,
  input  logic            re,
  input  logic [IW-1:0]   raddr,
  output ket_pkg::entry_t rdata
);
  import ket_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/ket_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ket_seq
// Command sequencer: sweeps the entry memory for key matches, free slots
// and the earliest expired entry, and updates the table.
// ----------------------------------------------------------------------------
module ket_seq #(
  parameter int TABLE_DEPTH = ket_pkg::DEFAULT_TABLE_DEPTH,
  parameter int DELAY_BITS  = ket_pkg::DEFAULT_DELAY_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  ket_in_if.sink           in_ch,
  output logic             res_valid,
  input  logic             res_ready,
  output ket_pkg::result_t res
);
  import ket_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_SWEEP, S_DONE, S_LAST, S_EMIT
  } state_t;

  state_t state_r, ret_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [TIME_W-1:0] now_r, ins_r;
  cmd_t cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [DELAY_W-1:0] delay_r;
  logic [CW-1:0] cnt_r;
  logic pipe_v_r;
  logic [IW-1:0] pipe_idx_r;
  logic hit_r, free_v_r, found_r, pend_v_r;
  logic [IW-1:0] hit_idx_r, free_idx_r, best_idx_r;
  logic [TIME_W-1:0] best_age_r, best_oage_r;
  logic [KEY_W-1:0] best_key_r, pend_key_r;
  logic [HANDLE_W-1:0] best_handle_r, pend_handle_r;
  logic [REL_W-1:0] n_r;
  result_t res_r;

  logic mem_we, mem_re;
  entry_t wdata, rdata;
  logic [TIME_W-1:0] age_c, oage_c;
  logic [DELAY_W-1:0] dmask;
  logic slot_v, better;
  state_t cont;

  ket_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (free_idx_r),
    .wdata (wdata),
    .re    (mem_re),
    .raddr (cnt_r[IW-1:0]),
    .rdata (rdata)
  );

  assign dmask  = DELAY_W'((17'd1 << DELAY_BITS) - 17'd1);
  assign mem_re = (state_r == S_SWEEP) && (cnt_r < CW'(TABLE_DEPTH));
  assign mem_we = (state_r == S_DONE) && (cmd_r == CMD_INSERT) && !hit_r && free_v_r;
  assign wdata  = '{key: key_r, handle: handle_r,
                    expiry: now_r + TIME_W'(delay_r & dmask), order: ins_r};
  assign age_c  = now_r - rdata.expiry;
  assign oage_c = ins_r - rdata.order;
  assign slot_v = valid_r[pipe_idx_r];
  assign better = !found_r || (age_c > best_age_r) ||
                  ((age_c == best_age_r) && (oage_c > best_oage_r));
  assign cont   = (n_r + REL_W'(1) == REL_W'(MAX_REL)) ? S_LAST : S_START;

  assign in_ch.ready = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_EMIT);
  assign res         = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      valid_r  <= '0;
      now_r    <= '0;
      ins_r    <= '0;
      pipe_v_r <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r    <= cmd_t'(in_ch.command);
            key_r    <= in_ch.key;
            handle_r <= in_ch.handle;
            delay_r  <= in_ch.delay;
            n_r      <= '0;
            pend_v_r <= 1'b0;
            if (cmd_t'(in_ch.command) == CMD_TICK) begin
              now_r <= now_r + TIME_W'(1);
            end
            state_r <= S_START;
          end
        end
        S_START: begin
          cnt_r    <= '0;
          pipe_v_r <= 1'b0;
          hit_r    <= 1'b0;
          free_v_r <= 1'b0;
          found_r  <= 1'b0;
          state_r  <= S_SWEEP;
        end
        S_SWEEP: begin
          if (mem_re) begin
            cnt_r <= cnt_r + CW'(1);
          end
          pipe_v_r   <= mem_re;
          pipe_idx_r <= cnt_r[IW-1:0];
          if (pipe_v_r) begin
            if (slot_v && rdata.key == key_r && !hit_r) begin
              hit_r     <= 1'b1;
              hit_idx_r <= pipe_idx_r;
            end
            if (!slot_v && !free_v_r) begin
              free_v_r   <= 1'b1;
              free_idx_r <= pipe_idx_r;
            end
            if (slot_v && !age_c[TIME_W-1] && better) begin
              found_r       <= 1'b1;
              best_idx_r    <= pipe_idx_r;
              best_age_r    <= age_c;
              best_oage_r   <= oage_c;
              best_key_r    <= rdata.key;
              best_handle_r <= rdata.handle;
            end
            if (pipe_idx_r == IW'(TABLE_DEPTH - 1)) begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          res_r.present <= (cmd_r == CMD_QUERY) && hit_r;
          unique case (cmd_r)
            CMD_INSERT: begin
              res_r.kind   <= KIND_INSERT;
              res_r.key    <= key_r;
              res_r.handle <= '0;
              res_r.last   <= 1'b1;
              ret_r        <= S_IDLE;
              state_r      <= S_EMIT;
              if (hit_r) begin
                res_r.status <= ST_DUP;
              end else if (!free_v_r) begin
                res_r.status <= ST_FULL;
              end else begin
                res_r.status        <= ST_OK;
                valid_r[free_idx_r] <= 1'b1;
                ins_r               <= ins_r + TIME_W'(1);
              end
            end
            CMD_REMOVE: begin
              res_r.kind   <= KIND_REMOVE;
              res_r.key    <= key_r;
              res_r.handle <= '0;
              res_r.last   <= 1'b1;
              ret_r        <= S_IDLE;
              state_r      <= S_EMIT;
              if (hit_r) begin
                res_r.status       <= ST_OK;
                valid_r[hit_idx_r] <= 1'b0;
              end else begin
                res_r.status <= ST_MISSING;
              end
            end
            CMD_QUERY: begin
              res_r.kind   <= KIND_QUERY;
              res_r.status <= ST_OK;
              res_r.key    <= key_r;
              res_r.handle <= '0;
              res_r.last   <= 1'b1;
              ret_r        <= S_IDLE;
              state_r      <= S_EMIT;
            end
            CMD_TICK: begin
              res_r.kind   <= KIND_RELEASE;
              res_r.status <= ST_OK;
              res_r.key    <= pend_key_r;
              res_r.handle <= pend_handle_r;
              res_r.last   <= !found_r;
              if (found_r) begin
                valid_r[best_idx_r] <= 1'b0;
                n_r           <= n_r + REL_W'(1);
                pend_v_r      <= 1'b1;
                pend_key_r    <= best_key_r;
                pend_handle_r <= best_handle_r;
                ret_r         <= cont;
                if (pend_v_r) begin
                  state_r <= S_EMIT;
                end else begin
                  state_r <= cont;
                end
              end else begin
                ret_r <= S_IDLE;
                if (pend_v_r) begin
                  state_r <= S_EMIT;
                end else begin
                  state_r <= S_IDLE;
                end
              end
            end
          endcase
        end
        S_LAST: begin
          res_r.kind    <= KIND_RELEASE;
          res_r.status  <= ST_OK;
          res_r.key     <= pend_key_r;
          res_r.handle  <= pend_handle_r;
          res_r.present <= 1'b0;
          res_r.last    <= 1'b1;
          ret_r         <= S_IDLE;
          state_r       <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) begin
            state_r <= ret_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/keyed_expiry_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_expiry_table
// Table of keyed entries with expiry times, released in expiry order on tick.
// ----------------------------------------------------------------------------
// Every command is served by full sweeps of the entry memory, one slot a
// cycle. An insert, remove or query runs one sweep and gives one word. A tick
// runs one sweep per released entry plus a closing sweep, which is skipped
// once sixteen entries are released, and gives at most sixteen release words.
// Results pass through an output register, so a word may wait there while
// the next sweep runs. There is no clearing pass after reset.
module keyed_expiry_table #(
  parameter int TABLE_DEPTH = ket_pkg::DEFAULT_TABLE_DEPTH,
  parameter int DELAY_BITS  = ket_pkg::DEFAULT_DELAY_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  ket_in_if.sink   in_ch,
  ket_out_if.source out_ch
);
  import ket_pkg::*;

  logic    res_valid, res_ready, out_v_r;
  result_t res, out_r;

  ket_seq #(.TABLE_DEPTH(TABLE_DEPTH), .DELAY_BITS(DELAY_BITS)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_ready) begin
      out_v_r <= res_valid;
      if (res_valid) begin
        out_r <= res;
      end
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.kind       = out_r.kind;
  assign out_ch.status     = out_r.status;
  assign out_ch.out_key    = out_r.key;
  assign out_ch.out_handle = out_r.handle;
  assign out_ch.present    = out_r.present;
  assign out_ch.last       = out_r.last;

endmodule
